@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion %m failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) `ASSERT_PROP(lbl, clk, rst_n, !(expr))
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

@@ rtl/sem_pkg.sv @@
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants of the Sobel edge magnitude block.
// ----------------------------------------------------------------------------
`default_nettype none

package sem_pkg;

    localparam int MAX_WIDTH_DEFAULT   = 1024;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam int PIX_W   = 8;
    localparam int FW_W    = 11;
    localparam int FH_W    = 16;
    localparam int CFG_W   = 16;
    localparam int ROW_W   = 16;
    localparam int COL_W   = 10;
    localparam int GRAD_W  = 11;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 16'd480;

    // register indexes of the configuration port
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic [PIX_W-1:0] MAG_MAX = 8'd255;

    // one classified pixel handed from the front end to the back end
    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic                     interior;
        logic                     has_out;
        logic                     last_col;
        logic                     last_row;
        logic [ROW_W-1:0]         row;
        logic [COL_W-1:0]         col;
    } job_t;

endpackage

`default_nettype wire

@@ rtl/sem_front.sv @@
// ----------------------------------------------------------------------------
// sem_front
// Accepts pixels, keeps line buffers and the 3x3 window, forms Gx and Gy.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [sem_pkg::PIX_W-1:0]   pixel,
    input  wire logic [sem_pkg::FW_W-1:0]    frame_width,
    input  wire logic [sem_pkg::FH_W-1:0]    frame_height,
    output logic                             job_push,
    input  wire logic                        job_full,
    output sem_pkg::job_t                    job
);
    import sem_pkg::*;

    localparam int XW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int EW = (XW + 1 > FW_W) ? XW + 1 : FW_W;
    localparam int CW = (XW > COL_W) ? XW : COL_W;

    localparam logic F_IDLE = 1'b0;
    localparam logic F_CALC = 1'b1;

    logic              f_state_reg, f_state_next;
    logic [XW-1:0]     x_reg, x_next;
    logic [ROW_W-1:0]  y_reg, y_next;
    logic [PIX_W-1:0]  pix_reg;
    logic [PIX_W-1:0]  top_reg, mid_reg;
    logic [PIX_W-1:0]  win_reg [6];

    logic [PIX_W-1:0]  one_up_mem [MAX_WIDTH];
    logic [PIX_W-1:0]  two_up_mem [MAX_WIDTH];

    logic              accept;
    logic              advance;
    logic [EW-1:0]     fw_ext, w_eff, x_ext;
    logic [FH_W-1:0]   h_eff;
    logic              last_col, last_row;
    logic [CW-1:0]     x_wide;
    logic [GRAD_W-1:0] sum_r, sum_l, sum_b, sum_t;

    assign accept  = push && (f_state_reg == F_IDLE);
    assign advance = (f_state_reg == F_CALC) && !job_full;
    assign full    = (f_state_reg != F_IDLE);

    always_comb
    begin
        fw_ext = EW'(frame_width);
        if (fw_ext < EW'(3))
            w_eff = EW'(3);
        else if (fw_ext > EW'(MAX_WIDTH))
            w_eff = EW'(MAX_WIDTH);
        else
            w_eff = fw_ext;
        h_eff    = (frame_height < 16'd3) ? 16'd3 : frame_height;
        x_ext    = EW'(x_reg);
        last_col = (x_ext >= w_eff - EW'(1));
        last_row = (y_reg >= h_eff - 16'd1);
        x_wide   = CW'(x_reg);
    end

    // right/left column sums and bottom/top row sums of the window
    always_comb
    begin
        sum_r = GRAD_W'(top_reg) + {(GRAD_W-1)'(mid_reg), 1'b0} + GRAD_W'(pix_reg);
        sum_l = GRAD_W'(win_reg[0]) + {(GRAD_W-1)'(win_reg[1]), 1'b0} + GRAD_W'(win_reg[2]);
        sum_b = GRAD_W'(win_reg[2]) + {(GRAD_W-1)'(win_reg[5]), 1'b0} + GRAD_W'(pix_reg);
        sum_t = GRAD_W'(win_reg[0]) + {(GRAD_W-1)'(win_reg[3]), 1'b0} + GRAD_W'(top_reg);
    end

    always_comb
    begin
        job.gx       = $signed(sum_r - sum_l);
        job.gy       = $signed(sum_b - sum_t);
        job.interior = (y_reg >= 16'd2) && (y_reg < h_eff) &&
                       (x_ext >= EW'(2)) && (x_ext < w_eff);
        job.has_out  = (y_reg != '0) && (x_reg != '0);
        job.last_col = last_col;
        job.last_row = last_row;
        job.row      = y_reg;
        job.col      = x_wide[COL_W-1:0];
    end

    assign job_push = advance;

    always_comb
    begin
        f_state_next = f_state_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        case (f_state_reg)
            F_IDLE:
            begin
                if (accept)
                    f_state_next = F_CALC;
            end
            F_CALC:
            begin
                if (advance)
                begin
                    f_state_next = F_IDLE;
                    if (last_col)
                    begin
                        x_next = '0;
                        y_next = last_row ? '0 : y_reg + 16'd1;
                    end
                    else
                    begin
                        x_next = x_reg + XW'(1);
                    end
                end
            end
            default: f_state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_state_reg <= F_IDLE;
            x_reg       <= '0;
            y_reg       <= '0;
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            f_state_reg <= f_state_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            if (advance)
            begin
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= top_reg;
                win_reg[4] <= mid_reg;
                win_reg[5] <= pix_reg;
            end
        end
    end

    // hold the pixel and fetch the two pixels above it
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg <= pixel;
            top_reg <= two_up_mem[x_reg];
            mid_reg <= one_up_mem[x_reg];
        end
    end

    // shift the column down through the line buffers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            two_up_mem[x_reg] <= mid_reg;
            one_up_mem[x_reg] <= pix_reg;
        end
    end

endmodule

`default_nettype wire

@@ rtl/sem_queue.sv @@
// ----------------------------------------------------------------------------
// sem_queue
// Short FIFO of classified pixels between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  sem_pkg::job_t      wr_data,
    output logic               q_full,
    input  wire logic          rd_en,
    output sem_pkg::job_t      rd_data,
    output logic               q_empty
);
    import sem_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    job_t          slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0] count_reg;
    logic          do_wr, do_rd;

    assign q_full  = (count_reg == NW'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + NW'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

@@ rtl/sem_back.sv @@
// ----------------------------------------------------------------------------
// sem_back
// Squares, bit-serial square root and result sequencing with output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sem_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    output logic                            job_pop,
    input  wire logic                       job_empty,
    input  sem_pkg::job_t                   job,
    output logic                            empty,
    input  wire logic                       pop,
    output logic [sem_pkg::PIX_W-1:0]       magnitude,
    output logic [sem_pkg::ROW_W-1:0]       out_row,
    output logic [sem_pkg::COL_W-1:0]       out_col,
    output logic                            last_of_run,
    output logic                            frame_end
);
    import sem_pkg::*;

    localparam logic [2:0] B_IDLE   = 3'd0;
    localparam logic [2:0] B_SQUARE = 3'd1;
    localparam logic [2:0] B_SUM    = 3'd2;
    localparam logic [2:0] B_ROOT   = 3'd3;
    localparam logic [2:0] B_EMIT   = 3'd4;

    logic [2:0]        b_state_reg, b_state_next;
    job_t              job_reg;
    logic [3:0]        mask_reg, mask_next;
    logic [19:0]       sq_x_reg, sq_y_reg;
    logic [15:0]       v_reg;
    logic [8:0]        rem_reg;
    logic [7:0]        root_reg;
    logic [2:0]        cnt_reg;
    logic [PIX_W-1:0]  mag_reg;

    logic              out_valid_reg;
    logic [PIX_W-1:0]  out_mag_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic              out_last_reg;
    logic              out_fe_reg;

    logic signed [GRAD_W-1:0] gx_s, gy_s;
    logic signed [21:0]       prod_x, prod_y;
    logic [20:0]              sum_sq;
    logic [10:0]              rem_sh, trial, rem_sub;
    logic                     ge;
    logic [7:0]               root_next;
    logic                     load_out;
    logic [1:0]               sel;
    logic [3:0]               sel_bit;
    logic [PIX_W-1:0]         e_mag;
    logic [ROW_W-1:0]         e_row;
    logic [COL_W-1:0]         e_col;

    assign gx_s   = job_reg.gx;
    assign gy_s   = job_reg.gy;
    assign prod_x = 22'(gx_s) * 22'(gx_s);
    assign prod_y = 22'(gy_s) * 22'(gy_s);
    assign sum_sq = 21'(sq_x_reg) + 21'(sq_y_reg);

    // one root bit per cycle, two radicand bits per step
    always_comb
    begin
        rem_sh    = {rem_reg, v_reg[15:14]};
        trial     = {1'b0, root_reg, 2'b01};
        ge        = (rem_sh >= trial);
        rem_sub   = rem_sh - trial;
        root_next = {root_reg[6:0], ge};
    end

    // pick the oldest pending result of this job
    always_comb
    begin
        if (mask_reg[0])
            sel = 2'd0;
        else if (mask_reg[1])
            sel = 2'd1;
        else if (mask_reg[2])
            sel = 2'd2;
        else
            sel = 2'd3;
        sel_bit = 4'b0001 << sel;
        e_mag   = (sel == 2'd0) ? mag_reg : '0;
        e_row   = (sel[1]) ? job_reg.row : job_reg.row - 16'd1;
        e_col   = (sel[0]) ? job_reg.col : job_reg.col - 10'd1;
    end

    assign load_out = (b_state_reg == B_EMIT) && (!out_valid_reg || pop);
    assign job_pop  = (b_state_reg == B_IDLE) && !job_empty;

    always_comb
    begin
        b_state_next = b_state_reg;
        mask_next    = mask_reg;
        case (b_state_reg)
            B_IDLE:
            begin
                if (!job_empty)
                begin
                    mask_next = job.has_out ?
                                {job.last_col && job.last_row, job.last_row, job.last_col, 1'b1}
                                : 4'b0000;
                    if (!job.has_out)
                        b_state_next = B_IDLE;
                    else if (job.interior)
                        b_state_next = B_SQUARE;
                    else
                        b_state_next = B_EMIT;
                end
            end
            B_SQUARE: b_state_next = B_SUM;
            B_SUM:    b_state_next = (sum_sq[20:16] != '0) ? B_EMIT : B_ROOT;
            B_ROOT:
            begin
                if (cnt_reg == 3'd0)
                    b_state_next = B_EMIT;
            end
            B_EMIT:
            begin
                if (load_out)
                begin
                    mask_next = mask_reg & ~sel_bit;
                    if ((mask_reg & ~sel_bit) == 4'b0000)
                        b_state_next = B_IDLE;
                end
            end
            default: b_state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_state_reg   <= B_IDLE;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            b_state_reg <= b_state_next;
            mask_reg    <= mask_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (b_state_reg)
            B_IDLE:
            begin
                if (!job_empty)
                begin
                    job_reg <= job;
                    mag_reg <= '0;
                end
            end
            B_SQUARE:
            begin
                sq_x_reg <= prod_x[19:0];
                sq_y_reg <= prod_y[19:0];
            end
            B_SUM:
            begin
                v_reg    <= sum_sq[15:0];
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= 3'd7;
                if (sum_sq[20:16] != '0)
                    mag_reg <= MAG_MAX;
            end
            B_ROOT:
            begin
                v_reg    <= {v_reg[13:0], 2'b00};
                rem_reg  <= ge ? rem_sub[8:0] : rem_sh[8:0];
                root_reg <= root_next;
                cnt_reg  <= cnt_reg - 3'd1;
                if (cnt_reg == 3'd0)
                    mag_reg <= root_next;
            end
            default:
            begin
            end
        endcase

        if (load_out)
        begin
            out_mag_reg  <= e_mag;
            out_row_reg  <= e_row;
            out_col_reg  <= e_col;
            out_last_reg <= ((mask_reg & ~sel_bit) == 4'b0000);
            out_fe_reg   <= (sel == 2'd3);
        end
    end

    assign empty       = !out_valid_reg;
    assign magnitude   = out_mag_reg;
    assign out_row     = out_row_reg;
    assign out_col     = out_col_reg;
    assign last_of_run = out_last_reg;
    assign frame_end   = out_fe_reg;

    `ASSERT_PROP(a_emit_has_work, clk, rst_n, (b_state_reg == B_EMIT) |-> (mask_reg != 4'b0000))
    `ASSERT_PROP(a_root_ends, clk, rst_n, (b_state_reg == B_ROOT && cnt_reg == 3'd0) |=> (b_state_reg == B_EMIT))
    `ASSERT_PROP(a_end_is_last, clk, rst_n, (out_valid_reg && out_fe_reg) |-> out_last_reg)
    `ASSERT_PROP(a_load_in_emit, clk, rst_n, $rose(out_valid_reg) |-> $past(b_state_reg == B_EMIT))

endmodule

`default_nettype wire

@@ rtl/sobel_edge_magnitude.sv @@
// ----------------------------------------------------------------------------
// sobel_edge_magnitude
// Streaming 3x3 Sobel gradient magnitude over a raster-order pixel stream.
// ----------------------------------------------------------------------------
// Push grayscale pixels in raster order for a frame of frame_width by
// frame_height; each pop gives one output pixel with its row and column,
// the clamped value floor(sqrt(Gx^2 + Gy^2)) (0 on the frame border),
// last_of_run on the final result of the pushed pixel and frame_end on the
// bottom-right corner. A pixel gives zero to four results, trailing by one
// row and one column. The front end reads the line buffers, then updates the
// window and writes them; it takes no new pixel until the last is queued.
// The back end sets the sustained rate: an interior pixel is loaded, squared
// and summed, then runs the bit-serial square root (skipped when the sum of
// squares saturates) and emits its results one by one; a border pixel is
// loaded and emits its results, and a pixel without results is only loaded.
// A four-entry queue between the two ends absorbs their different paces and
// an output register lets a result wait while new pixels are taken. Line
// buffers start undefined; write frame_width and frame_height only while the
// block is idle. The frame position is kept across idle periods.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_edge_magnitude #(
    parameter int MAX_WIDTH   = sem_pkg::MAX_WIDTH_DEFAULT,
    parameter int QUEUE_DEPTH = sem_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_index,
    input  wire logic [sem_pkg::CFG_W-1:0]   cfg_data,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [sem_pkg::PIX_W-1:0]   pixel,
    output logic                             empty,
    input  wire logic                        pop,
    output logic [sem_pkg::PIX_W-1:0]        magnitude,
    output logic [sem_pkg::ROW_W-1:0]        out_row,
    output logic [sem_pkg::COL_W-1:0]        out_col,
    output logic                             last_of_run,
    output logic                             frame_end
);
    import sem_pkg::*;

    logic [FW_W-1:0] frame_width_reg;
    logic [FH_W-1:0] frame_height_reg;

    job_t front_job, back_job;
    logic front_push, q_full, back_pop, q_empty;

    // configuration registers; read combinationally by the front end, so a write also affects the item in progress
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FH_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // front end: accept pixels, advance the window, classify
    sem_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .pixel        (pixel),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .job_push     (front_push),
        .job_full     (q_full),
        .job          (front_job)
    );

    // hold classified items until the back end drains them
    sem_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_push),
        .wr_data (front_job),
        .q_full  (q_full),
        .rd_en   (back_pop),
        .rd_data (back_job),
        .q_empty (q_empty)
    );

    // back end: magnitude and result sequencing
    sem_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_pop     (back_pop),
        .job_empty   (q_empty),
        .job         (back_job),
        .empty       (empty),
        .pop         (pop),
        .magnitude   (magnitude),
        .out_row     (out_row),
        .out_col     (out_col),
        .last_of_run (last_of_run),
        .frame_end   (frame_end)
    );

endmodule

`default_nettype wire

@@ tb/sv/sem_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_checker
// Watches the pixel, result and register channels of the Sobel block, keeps
// its own line buffers and window, and compares every popped result with the
// oldest predicted one.
// ----------------------------------------------------------------------------
module sem_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [sem_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        push,
    input  logic                        full,
    input  logic [sem_pkg::PIX_W-1:0]   pixel,
    input  logic                        empty,
    input  logic                        pop,
    input  logic [sem_pkg::PIX_W-1:0]   magnitude,
    input  logic [sem_pkg::ROW_W-1:0]   out_row,
    input  logic [sem_pkg::COL_W-1:0]   out_col,
    input  logic                        last_of_run,
    input  logic                        frame_end,
    output int                          errors,
    output int                          pending
);
    import sem_pkg::*;

    localparam int LINE_DEPTH = MAX_WIDTH_DEFAULT;
    localparam int PRINT_CAP  = 40;

    typedef struct packed {
        logic [PIX_W-1:0] magnitude;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last_of_run;
        logic             frame_end;
    } edge_px_t;

    logic [FW_W-1:0]  width_reg;
    logic [FH_W-1:0]  height_reg;
    logic [PIX_W-1:0] line_up1 [LINE_DEPTH];
    logic [PIX_W-1:0] line_up2 [LINE_DEPTH];
    logic [PIX_W-1:0] win [6];
    int               next_col;
    int               next_row;
    edge_px_t         awaited_px [$];
    int               fail_total;
    int               printed;

    function automatic int root_floor(input int unsigned s);
        int unsigned r;
        r = 0;
        for (int b = 8; b >= 0; b--) begin
            if ((r | (1 << b)) * (r | (1 << b)) <= s)
                r = r | (1 << b);
        end
        return int'(r);
    endfunction

    function automatic edge_px_t make_px(input logic [PIX_W-1:0] mag, input int r,
                                         input int c, input logic fe);
        edge_px_t p;
        p.magnitude   = mag;
        p.row         = ROW_W'(r);
        p.col         = COL_W'(c);
        p.last_of_run = 1'b0;
        p.frame_end   = fe;
        return p;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] wanted, input int r, input int c);
        fail_total++;
        if (printed < PRINT_CAP) begin
            $display("mismatch: %s at row %0d col %0d: got %0h, wanted %0h",
                     what, r, c, got, wanted);
            printed++;
        end
    endtask

    // Run one pixel through the filter and queue the results it causes.
    task automatic filter_pixel(input logic [PIX_W-1:0] px);
        int               w, h, x, y, xi;
        int               l0, l1, l2, m0, m2, r0, r1, r2, gx, gy;
        int unsigned      ssq;
        logic [PIX_W-1:0] top_px, mid_px, mag;
        logic             lastcol, lastrow;
        edge_px_t         batch [$];
        edge_px_t         p;
        w = int'(width_reg);
        if (w < 3) w = 3;
        if (w > LINE_DEPTH) w = LINE_DEPTH;
        h = int'(height_reg);
        if (h < 3) h = 3;
        x = next_col;
        y = next_row;
        xi = (x < LINE_DEPTH) ? x : LINE_DEPTH - 1;
        top_px = line_up2[xi];
        mid_px = line_up1[xi];
        lastcol = (x >= w - 1);
        lastrow = (y >= h - 1);
        mag = '0;
        if (y >= 2 && y - 1 < h - 1 && x >= 2 && x - 1 < w - 1) begin
            l0 = int'(win[0]);
            l1 = int'(win[1]);
            l2 = int'(win[2]);
            m0 = int'(win[3]);
            m2 = int'(win[5]);
            r0 = int'(top_px);
            r1 = int'(mid_px);
            r2 = int'(px);
            gx = (r0 + 2 * r1 + r2) - (l0 + 2 * l1 + l2);
            gy = (l2 + 2 * m2 + r2) - (l0 + 2 * m0 + r0);
            ssq = int'(gx * gx + gy * gy);
            mag = (ssq >= 65536) ? MAG_MAX : PIX_W'(root_floor(ssq));
        end
        if (y >= 1 && x >= 1) begin
            batch.push_back(make_px(mag, y - 1, x - 1, 1'b0));
            if (lastcol) batch.push_back(make_px('0, y - 1, x, 1'b0));
            if (lastrow) batch.push_back(make_px('0, y, x - 1, 1'b0));
            if (lastcol && lastrow) batch.push_back(make_px('0, y, x, 1'b1));
        end
        foreach (batch[i]) begin
            p = batch[i];
            p.last_of_run = (i == batch.size() - 1);
            awaited_px.push_back(p);
        end
        line_up2[xi] = mid_px;
        line_up1[xi] = px;
        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = top_px;
        win[4] = mid_px;
        win[5] = px;
        if (lastcol) begin
            next_col = 0;
            next_row = lastrow ? 0 : ((y + 1) & 16'hFFFF);
        end else begin
            next_col = x + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        edge_px_t want;
        if (!rst_n) begin
            width_reg = FRAME_WIDTH_RESET;
            height_reg = FRAME_HEIGHT_RESET;
            for (int i = 0; i < LINE_DEPTH; i++) begin
                line_up1[i] = '0;
                line_up2[i] = '0;
            end
            for (int i = 0; i < 6; i++) win[i] = '0;
            next_col = 0;
            next_row = 0;
            awaited_px.delete();
            fail_total = 0;
            printed = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_FRAME_WIDTH) width_reg = cfg_data[FW_W-1:0];
                else height_reg = cfg_data[FH_W-1:0];
            end
            if (pop && !empty) begin
                if (awaited_px.size() == 0) begin
                    report_mismatch("result with nothing awaited", 32'(magnitude), '0,
                                    int'(out_row), int'(out_col));
                end else begin
                    want = awaited_px.pop_front();
                    if (magnitude !== want.magnitude)
                        report_mismatch("magnitude", 32'(magnitude), 32'(want.magnitude),
                                        int'(want.row), int'(want.col));
                    if (out_row !== want.row)
                        report_mismatch("out_row", 32'(out_row), 32'(want.row),
                                        int'(want.row), int'(want.col));
                    if (out_col !== want.col)
                        report_mismatch("out_col", 32'(out_col), 32'(want.col),
                                        int'(want.row), int'(want.col));
                    if (last_of_run !== want.last_of_run)
                        report_mismatch("last_of_run", 32'(last_of_run),
                                        32'(want.last_of_run), int'(want.row),
                                        int'(want.col));
                    if (frame_end !== want.frame_end)
                        report_mismatch("frame_end", 32'(frame_end), 32'(want.frame_end),
                                        int'(want.row), int'(want.col));
                end
            end
            if (push && !full) filter_pixel(pixel);
        end
        errors <= fail_total;
        pending <= awaited_px.size();
    end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the streaming Sobel edge magnitude block.
// ----------------------------------------------------------------------------
// Pushes whole frames of grayscale pixels under several frame sizes, from the
// smallest the block allows up to a dozen columns, with random gaps on the
// pixel side and random pop stalls on the result side. A checker beside the
// block predicts every result and compares it; this module only drives and
// judges. Register writes happen only with the block drained and settled,
// apart from two deliberate writes in the middle of a frame (height cut,
// width cut).
// ----------------------------------------------------------------------------
module tb;
    import sem_pkg::*;

    // Settle time after the last result before a register write or the end.
    localparam int DRAIN_CYCLES   = 48;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 70;

    typedef enum int {
        PAT_RANDOM,
        PAT_ZERO,
        PAT_FULL,
        PAT_DIAGONAL,
        PAT_CHECKER,
        PAT_RAMP,
        PAT_SOFT
    } pattern_kind_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic               cfg_index = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]   cfg_data  = '0;
    logic               push      = 1'b0;
    logic [PIX_W-1:0]   pixel     = '0;
    logic               pop       = 1'b0;
    logic               full;
    logic               empty;
    logic [PIX_W-1:0]   magnitude;
    logic [ROW_W-1:0]   out_row;
    logic [COL_W-1:0]   out_col;
    logic               last_of_run;
    logic               frame_end;

    int errors;
    int pending;
    int cur_w        = 640;
    int cur_h        = 480;
    int idle_cycles  = 0;
    bit hold_request = 1'b0;
    bit send_burst   = 1'b0;
    bit recv_burst   = 1'b0;

    always #1 clk = ~clk;

    sobel_edge_magnitude dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .pixel       (pixel),
        .empty       (empty),
        .pop         (pop),
        .magnitude   (magnitude),
        .out_row     (out_row),
        .out_col     (out_col),
        .last_of_run (last_of_run),
        .frame_end   (frame_end)
    );

    sem_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .pixel       (pixel),
        .empty       (empty),
        .pop         (pop),
        .magnitude   (magnitude),
        .out_row     (out_row),
        .out_col     (out_col),
        .last_of_run (last_of_run),
        .frame_end   (frame_end),
        .errors      (errors),
        .pending     (pending)
    );

    // Mostly back to back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [PIX_W-1:0] pattern_px(input pattern_kind_t kind,
                                                    input int r, input int c);
        case (kind)
            PAT_ZERO:     return '0;
            PAT_FULL:     return '1;
            // sharp diagonal step drives the sum of squares into saturation
            PAT_DIAGONAL: return (c > r) ? 8'hFF : 8'h00;
            PAT_CHECKER:  return ((r + c) & 1) ? 8'hFF : 8'h00;
            PAT_RAMP:     return PIX_W'(r * 7 + c * 13);
            // gentle noise around mid gray keeps the root out of saturation
            PAT_SOFT:     return PIX_W'($urandom_range(100, 156));
            default:      return PIX_W'($urandom);
        endcase
    endfunction

    // Write one register and mirror its effective value for frame sizing.
    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
        int v;
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == REG_FRAME_WIDTH) begin
            v = int'(data[FW_W-1:0]);
            cur_w = (v < 3) ? 3 : ((v > MAX_WIDTH_DEFAULT) ? MAX_WIDTH_DEFAULT : v);
        end else begin
            v = int'(data[FH_W-1:0]);
            cur_h = (v < 3) ? 3 : v;
        end
    endtask

    // Offer count pixels in raster order; each returns once the item is taken.
    task automatic send_pixels(input pattern_kind_t kind, input int count);
        int gap;
        for (int k = 0; k < count; k++) begin
            gap = send_burst ? 0 : pick_gap();
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            push <= 1'b1;
            pixel <= pattern_px(kind, k / cur_w, k % cur_w);
            // full is stable between edges: sample it in the low phase
            @(negedge clk);
            while (full) @(negedge clk);
            @(posedge clk);
        end
    endtask

    // Hold the input until every awaited result is out, then let the block
    // settle, since a pixel without results may still be in flight.
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [CFG_W-1:0] random_width();
        int w;
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
        // junk above the width field must be dropped by the block
        if ($urandom_range(0, 3) == 0) return {5'($urandom), 11'(w)};
        return CFG_W'(w);
    endfunction

    function automatic logic [CFG_W-1:0] random_height();
        if ($urandom_range(0, 9) == 0) return CFG_W'($urandom_range(0, 2));
        return CFG_W'($urandom_range(3, 8));
    endfunction

    // Result side: pop with random stalls; a hold request parks pop low for
    // a long stretch so the block backs up and raises full.
    initial begin : receiver
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                gap = recv_burst ? 0 : pick_gap();
                if (gap > 0) begin
                    pop <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            pop <= 1'b1;
            @(negedge clk);
            while (empty) @(negedge clk);
            @(posedge clk);
            if ($urandom_range(0, 39) == 0) recv_burst = ~recv_burst;
        end
    end

    // Progress watchdog: any accepted item or result clears the count.
    always @(posedge clk) begin
        if (!rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item or result accepted for %0d cycles", idle_cycles);
            $display("tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int            random_items;
        pattern_kind_t kind;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: register values below the legal range clamp to 3x3;
        // the diagonal step covers pixel extremes and a saturated root.
        write_reg(REG_FRAME_WIDTH, 16'd0);
        write_reg(REG_FRAME_HEIGHT, 16'd1);
        send_pixels(PAT_DIAGONAL, cur_w * cur_h);
        drain();
        // Width with junk in the upper bits, height below range again.
        write_reg(REG_FRAME_WIDTH, 16'hF805);
        write_reg(REG_FRAME_HEIGHT, 16'd2);
        send_pixels(PAT_RANDOM, cur_w * cur_h);
        drain();

        // Random frames of small sizes, sizes and content changing between.
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 3))
                0: ;
                1: write_reg(REG_FRAME_WIDTH, random_width());
                2: write_reg(REG_FRAME_HEIGHT, random_height());
                default: begin
                    write_reg(REG_FRAME_WIDTH, random_width());
                    write_reg(REG_FRAME_HEIGHT, random_height());
                end
            endcase
            send_burst = ($urandom_range(0, 3) == 0);
            kind = pattern_kind_t'($urandom_range(0, int'(PAT_SOFT)));
            send_pixels(kind, cur_w * cur_h);
            drain();
            random_items += cur_w * cur_h;
        end

        // Back pressure: stop popping while pixels keep coming back to back.
        write_reg(REG_FRAME_WIDTH, 16'd8);
        write_reg(REG_FRAME_HEIGHT, 16'd6);
        send_burst = 1'b1;
        hold_request = 1'b1;
        send_pixels(PAT_RANDOM, cur_w * cur_h);
        drain();
        send_burst = 1'b0;

        // Tallest height, then cut mid-frame: rows already past the new
        // last row count as last row.
        write_reg(REG_FRAME_WIDTH, 16'd3);
        write_reg(REG_FRAME_HEIGHT, 16'hFFFF);
        send_pixels(PAT_CHECKER, 5 * cur_w);
        drain();
        write_reg(REG_FRAME_HEIGHT, 16'd3);
        send_pixels(PAT_SOFT, cur_w);
        drain();

        // Width cut mid-row: the current column is already past the new last
        // column, so the rest of that row is closed at once.
        write_reg(REG_FRAME_WIDTH, 16'd8);
        write_reg(REG_FRAME_HEIGHT, 16'd4);
        send_pixels(PAT_RANDOM, 2 * 8 + 5);
        drain();
        write_reg(REG_FRAME_WIDTH, 16'd4);
        send_pixels(PAT_RANDOM, 1 + 4);
        drain();

        // One more ordinary frame after the odd cases.
        write_reg(REG_FRAME_WIDTH, 16'd5);
        write_reg(REG_FRAME_HEIGHT, 16'd4);
        send_pixels(PAT_SOFT, cur_w * cur_h);
        drain();

        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
